### hdl/acc_pkg.sv
// Shared types and constants for the adjacent channel clusterer.
// Used by acc_ctrl, acc_dp and the top level; no dependencies.
package acc_pkg;

   localparam int ID_PORT_W   = 24;
   localparam int SIZE_PORT_W = 7;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // store write data source
   typedef enum logic [1:0] {
      WSEL_REQ = 2'd0,
      WSEL_RD  = 2'd1,
      WSEL_V   = 2'd2
   } wsel_type;

   typedef struct packed {
      logic     mem_we;
      wsel_type wr_sel;
      logic     load_v;
      logic     scan_first;
      logic     scan_next;
      logic     emit;
      logic     emit_last;
      logic     drop_hit;
      logic     clear_event;
   } cmd_type;

   typedef struct packed {
      logic rd_gt_v;
      logic run_cont;
      logic out_free;
   } status_type;

endpackage

### hdl/acc_ctrl.sv
// Sequencer for the clusterer: hit loading, in-place insertion sort and run scan.
// Depends on acc_pkg; drives acc_dp through command and address signals.
module acc_ctrl #(
   parameter int MAX_HITS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_kind,
   input  logic                        req_hit_valid,
   output logic                        req_stall,
   input  acc_pkg::status_type         status,
   output acc_pkg::cmd_type            cmd,
   output logic [$clog2(MAX_HITS)-1:0] wr_addr,
   output logic [$clog2(MAX_HITS)-1:0] rd_addr
);

   localparam int AW = $clog2(MAX_HITS);
   localparam int CW = $clog2(MAX_HITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK,
      ST_PICKW,
      ST_CMP,
      ST_SRD,
      ST_SEV,
      ST_FINAL
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]   i_ff, i_in;
   logic [CW-1:0]   j_ff, j_in;
   logic [CW-1:0]   k_ff, k_in;
   logic [CW-1:0]   i_next;
   logic [CW-1:0]   j_back;
   logic [CW-1:0]   k_next;

   assign i_next = i_ff + CW'(1);
   assign j_back = j_ff - CW'(2);
   assign k_next = k_ff + CW'(1);

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cmd      = '0;
      cmd.wr_sel = acc_pkg::WSEL_REQ;
      wr_addr  = cnt_ff[AW-1:0];
      rd_addr  = k_ff[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == acc_pkg::KIND_LOAD) begin
                  if (req_hit_valid) begin
                     if (cnt_ff < CW'(MAX_HITS)) begin
                        cmd.mem_we = 1'b1;
                        cnt_in     = cnt_ff + CW'(1);
                     end else begin
                        cmd.drop_hit = 1'b1;
                     end
                  end
               end else if (cnt_ff == '0) begin
                  cmd.clear_event = 1'b1;
               end else if (cnt_ff == CW'(1)) begin
                  k_in     = '0;
                  state_in = ST_SRD;
               end else begin
                  i_in     = CW'(1);
                  state_in = ST_PICK;
               end
            end
         end
         ST_PICK: begin
            rd_addr  = i_ff[AW-1:0];
            state_in = ST_PICKW;
         end
         ST_PICKW: begin
            // hold the element being inserted, fetch its left neighbor
            cmd.load_v = 1'b1;
            rd_addr    = AW'(i_ff - CW'(1));
            j_in       = i_ff;
            state_in   = ST_CMP;
         end
         ST_CMP: begin
            wr_addr    = j_ff[AW-1:0];
            cmd.mem_we = 1'b1;
            if (j_ff != '0 && status.rd_gt_v) begin
               // shift right and prefetch the next neighbor down
               cmd.wr_sel = acc_pkg::WSEL_RD;
               rd_addr    = j_back[AW-1:0];
               j_in       = j_ff - CW'(1);
            end else begin
               cmd.wr_sel = acc_pkg::WSEL_V;
               if (i_next == cnt_ff) begin
                  k_in     = '0;
                  state_in = ST_SRD;
               end else begin
                  i_in     = i_next;
                  state_in = ST_PICK;
               end
            end
         end
         ST_SRD: begin
            state_in = ST_SEV;
         end
         ST_SEV: begin
            if (k_ff == '0) begin
               cmd.scan_first = 1'b1;
            end else if (status.run_cont) begin
               cmd.scan_next = 1'b1;
            end else if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.scan_first = 1'b1;
            end
            if (k_ff == '0 || status.run_cont || status.out_free) begin
               if (k_next == cnt_ff) begin
                  state_in = ST_FINAL;
               end else begin
                  k_in     = k_next;
                  state_in = ST_SRD;
               end
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.clear_event = 1'b1;
               cnt_in          = '0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

endmodule

### hdl/acc_dp.sv
// Datapath for the clusterer: ID store, sort compare, run tracking, result register.
// Depends on acc_pkg; controlled by acc_ctrl.
module acc_dp #(
   parameter int MAX_HITS = 64,
   parameter int ID_WIDTH = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  acc_pkg::cmd_type                    cmd,
   input  logic [$clog2(MAX_HITS)-1:0]         wr_addr,
   input  logic [$clog2(MAX_HITS)-1:0]         rd_addr,
   input  logic [acc_pkg::ID_PORT_W-1:0]       req_channel_id,
   output acc_pkg::status_type                 status,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [acc_pkg::ID_PORT_W-1:0]       rsp_cluster_first,
   output logic [acc_pkg::SIZE_PORT_W-1:0]     rsp_cluster_size,
   output logic                                rsp_last_cluster,
   output logic                                rsp_overflow
);

   localparam int SW  = (ID_WIDTH < acc_pkg::ID_PORT_W) ? ID_WIDTH : acc_pkg::ID_PORT_W;
   localparam int SZW = $clog2(MAX_HITS + 1);

   logic [SW-1:0]  store_mem [MAX_HITS];
   logic [SW-1:0]  rd_data_ff;
   logic [SW-1:0]  wr_data;
   logic [SW-1:0]  v_ff;
   logic [SW-1:0]  first_ff;
   logic [SW-1:0]  prev_ff;
   logic [SZW-1:0] size_ff;
   logic           dropped_ff;
   logic           rsp_valid_ff;
   logic [SW-1:0]  rsp_first_ff;
   logic [SZW-1:0] rsp_size_ff;
   logic           rsp_last_ff;
   logic           rsp_ovf_ff;

   always_comb begin
      case (cmd.wr_sel)
         acc_pkg::WSEL_RD: wr_data = rd_data_ff;
         acc_pkg::WSEL_V:  wr_data = v_ff;
         default:          wr_data = req_channel_id[SW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign status.rd_gt_v  = (rd_data_ff > v_ff);
   // a duplicate does not continue a run
   assign status.run_cont = ({1'b0, rd_data_ff} == ({1'b0, prev_ff} + (SW + 1)'(1)));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load_v) begin
         v_ff <= rd_data_ff;
      end
      if (cmd.scan_first) begin
         first_ff <= rd_data_ff;
         prev_ff  <= rd_data_ff;
         size_ff  <= SZW'(1);
      end else if (cmd.scan_next) begin
         prev_ff <= rd_data_ff;
         size_ff <= size_ff + SZW'(1);
      end
      if (cmd.emit) begin
         rsp_first_ff <= first_ff;
         rsp_size_ff  <= size_ff;
         rsp_last_ff  <= cmd.emit_last;
         rsp_ovf_ff   <= dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.drop_hit) begin
            dropped_ff <= 1'b1;
         end else if (cmd.clear_event) begin
            dropped_ff <= 1'b0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cluster_first = acc_pkg::ID_PORT_W'(rsp_first_ff);
   assign rsp_cluster_size  = acc_pkg::SIZE_PORT_W'(rsp_size_ff);
   assign rsp_last_cluster  = rsp_last_ff;
   assign rsp_overflow      = rsp_ovf_ff;

endmodule

### hdl/adjacent_channel_clusterer.sv
// Load transactions are accepted back to back.
// End of event with n hits: the hits are insertion-sorted in place, then the scan
// reads each hit in turn and emits a cluster at the end of each run.
// Results leave through a registered output; the scan waits while it is stalled.
// Reset (synchronous, active high) clears the sequencer, hit count and drop flag;
// the ID store is not cleared.
module adjacent_channel_clusterer #(
   parameter int MAX_HITS = 64,
   parameter int ID_WIDTH = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_kind,
   input  logic [acc_pkg::ID_PORT_W-1:0]   req_channel_id,
   input  logic                            req_hit_valid,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [acc_pkg::ID_PORT_W-1:0]   rsp_cluster_first,
   output logic [acc_pkg::SIZE_PORT_W-1:0] rsp_cluster_size,
   output logic                            rsp_last_cluster,
   output logic                            rsp_overflow
);

   localparam int AW = $clog2(MAX_HITS);

   acc_pkg::cmd_type    cmd;
   acc_pkg::status_type status;
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       rd_addr;

   acc_ctrl #(
      .MAX_HITS (MAX_HITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_kind      (req_kind),
      .req_hit_valid (req_hit_valid),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd),
      .wr_addr       (wr_addr),
      .rd_addr       (rd_addr)
   );

   acc_dp #(
      .MAX_HITS (MAX_HITS),
      .ID_WIDTH (ID_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .wr_addr           (wr_addr),
      .rd_addr           (rd_addr),
      .req_channel_id    (req_channel_id),
      .status            (status),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_cluster_first (rsp_cluster_first),
      .rsp_cluster_size  (rsp_cluster_size),
      .rsp_last_cluster  (rsp_last_cluster),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

### hdl/acc_checker.sv
// Port-level checks for adjacent_channel_clusterer, attached by bind.
// Depends on acc_pkg for port widths.
module acc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_kind,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [acc_pkg::ID_PORT_W-1:0]   rsp_cluster_first,
   input logic [acc_pkg::SIZE_PORT_W-1:0] rsp_cluster_size,
   input logic                            rsp_last_cluster,
   input logic                            rsp_overflow
);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // every cluster holds at least one channel
   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cluster_size != '0)
      else $error("empty cluster emitted");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cluster_first)
         && $stable(rsp_cluster_size) && $stable(rsp_last_cluster)
         && $stable(rsp_overflow))
      else $error("stalled result changed");

   // loading a hit never blocks the next transaction
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == acc_pkg::KIND_LOAD |=> !req_stall)
      else $error("stall after hit load");

endmodule

bind adjacent_channel_clusterer acc_checker u_acc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_kind          (req_kind),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_cluster_first (rsp_cluster_first),
   .rsp_cluster_size  (rsp_cluster_size),
   .rsp_last_cluster  (rsp_last_cluster),
   .rsp_overflow      (rsp_overflow)
);

### tb/tb_adjacent_channel_clusterer.sv
`timescale 1ns / 100ps
// Self-checking testbench for adjacent_channel_clusterer: a table of directed
// transactions, then random events, checked against a cluster predictor or typed results.
// Depends on acc_pkg and the adjacent_channel_clusterer RTL.
module tb_adjacent_channel_clusterer;

   localparam int MAX_HITS = 64;

   typedef struct packed {
      logic [acc_pkg::ID_PORT_W-1:0]   first_ch;
      logic [acc_pkg::SIZE_PORT_W-1:0] n_ch;
      logic                            is_last;
      logic                            ovf;
   } cluster_rec_type;

   typedef struct packed {
      logic                          kind;
      logic [acc_pkg::ID_PORT_W-1:0] id;
      logic                          hv;
      int                            reps;
      int                            step;
      int                            n_exp;   // -1: predicted, 0: no cluster, 1: the typed one
      cluster_rec_type               want;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_kind;
   logic [acc_pkg::ID_PORT_W-1:0]   req_channel_id;
   logic                            req_hit_valid;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [acc_pkg::ID_PORT_W-1:0]   rsp_cluster_first;
   logic [acc_pkg::SIZE_PORT_W-1:0] rsp_cluster_size;
   logic                            rsp_last_cluster;
   logic                            rsp_overflow;

   // predictor state
   logic [acc_pkg::ID_PORT_W-1:0] hit_ids [MAX_HITS];
   int                            hit_total;
   bit                            hits_dropped;
   cluster_rec_type               new_clusters[$];
   cluster_rec_type               expected_clusters[$];

   int fail_count = 0;
   bit quiet = 1'b0;
   bit squeeze = 1'b0;

   stim_row_type plan [21];

   adjacent_channel_clusterer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_channel_id    (req_channel_id),
      .req_hit_valid     (req_hit_valid),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cluster_first (rsp_cluster_first),
      .rsp_cluster_size  (rsp_cluster_size),
      .rsp_last_cluster  (rsp_last_cluster),
      .rsp_overflow      (rsp_overflow)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

   // Stores hits, and on end of event sorts them and splits them into runs.
   task automatic model_transaction(input logic kind,
                                    input logic [acc_pkg::ID_PORT_W-1:0] id,
                                    input logic hv);
      logic [acc_pkg::ID_PORT_W-1:0] sorted [MAX_HITS];
      logic [acc_pkg::ID_PORT_W-1:0] v;
      logic [acc_pkg::ID_PORT_W-1:0] run_first;
      int                            run_len;
      int                            j;
      cluster_rec_type               rec;
      new_clusters.delete();
      if (kind == acc_pkg::KIND_LOAD) begin
         if (hv) begin
            if (hit_total < MAX_HITS) begin
               hit_ids[hit_total] = id;
               hit_total++;
            end else begin
               hits_dropped = 1'b1;
            end
         end
      end else begin
         if (hit_total > 0) begin
            sorted = hit_ids;
            for (int i = 1; i < hit_total; i++) begin
               v = sorted[i];
               j = i;
               while (j > 0 && sorted[j-1] > v) begin
                  sorted[j] = sorted[j-1];
                  j--;
               end
               sorted[j] = v;
            end
            run_first = sorted[0];
            run_len = 1;
            // an equal ID does not extend a run; it opens a new cluster
            for (int i = 1; i < hit_total; i++) begin
               if ({1'b0, sorted[i]} == {1'b0, sorted[i-1]} + 25'd1) begin
                  run_len++;
               end else begin
                  rec = {run_first, acc_pkg::SIZE_PORT_W'(run_len), 1'b0, hits_dropped};
                  new_clusters = {new_clusters, rec};
                  run_first = sorted[i];
                  run_len = 1;
               end
            end
            rec = {run_first, acc_pkg::SIZE_PORT_W'(run_len), 1'b1, hits_dropped};
            new_clusters = {new_clusters, rec};
         end
         hit_total = 0;
         hits_dropped = 1'b0;
      end
   endtask

   // Offers one transaction from a falling edge and returns at the falling edge
   // after it was accepted.
   task automatic send_req(input logic kind, input logic [acc_pkg::ID_PORT_W-1:0] id,
                           input logic hv, input int n_exp, input cluster_rec_type want);
      if (!quiet) begin
         while ($urandom_range(99) < 6) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_channel_id <= id;
      req_hit_valid  <= hv;
      do @(posedge clock); while (req_stall !== 1'b0);
      model_transaction(kind, id, hv);
      if (n_exp < 0) begin
         expected_clusters = {expected_clusters, new_clusters};
      end else if (n_exp == 1) begin
         expected_clusters = {expected_clusters, want};
      end
      @(negedge clock);
   endtask

   // result side: long hold-off once asked for, otherwise sparse random stalls
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze && !held) begin
            held = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 6);
         end
      end
   end

   always @(posedge clock) begin
      cluster_rec_type want;
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_clusters.size() == 0) begin
            $display("%0t unexpected cluster: expected none, got first %h size %0d",
                     $time, rsp_cluster_first, rsp_cluster_size);
            fail_count++;
         end else begin
            want = expected_clusters.pop_front();
            if (rsp_cluster_first !== want.first_ch) begin
               $display("%0t cluster_first: expected %h, got %h",
                        $time, want.first_ch, rsp_cluster_first);
               fail_count++;
            end
            if (rsp_cluster_size !== want.n_ch) begin
               $display("%0t cluster_size: expected %0d, got %0d",
                        $time, want.n_ch, rsp_cluster_size);
               fail_count++;
            end
            if (rsp_last_cluster !== want.is_last) begin
               $display("%0t last_cluster: expected %b, got %b",
                        $time, want.is_last, rsp_last_cluster);
               fail_count++;
            end
            if (rsp_overflow !== want.ovf) begin
               $display("%0t overflow: expected %b, got %b",
                        $time, want.ovf, rsp_overflow);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int                            items;
      int                            ev;
      int                            n_hits;
      int                            spread;
      int                            style;
      logic [acc_pkg::ID_PORT_W-1:0] base;
      logic [acc_pkg::ID_PORT_W-1:0] id;
      logic                          hv;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = acc_pkg::KIND_LOAD;
      req_channel_id = '0;
      req_hit_valid  = 1'b0;
      hit_total      = 0;
      hits_dropped   = 1'b0;

      plan = '{
         // end of an empty event, with its ignored fields set
         '{acc_pkg::KIND_END,  24'hFFFFFF, 1'b1, 1,  0,  0, '0},
         '{acc_pkg::KIND_LOAD, 24'hFFFFFF, 1'b1, 1,  0, -1, '0},
         '{acc_pkg::KIND_END,  24'h000000, 1'b0, 1,  0,  1, {24'hFFFFFF, 7'd1, 1'b1, 1'b0}},
         '{acc_pkg::KIND_LOAD, 24'h000000, 1'b1, 1,  0, -1, '0},
         '{acc_pkg::KIND_LOAD, 24'h000005, 1'b0, 1,  0, -1, '0},
         '{acc_pkg::KIND_END,  24'h000000, 1'b0, 1,  0,  1, {24'h000000, 7'd1, 1'b1, 1'b0}},
         // top of the ID range, and no wrap to zero
         '{acc_pkg::KIND_LOAD, 24'hFFFFFE, 1'b1, 2,  1, -1, '0},
         '{acc_pkg::KIND_LOAD, 24'h000000, 1'b1, 1,  0, -1, '0},
         '{acc_pkg::KIND_END,  24'h000000, 1'b0, 1,  0, -1, '0},
         // duplicate IDs
         '{acc_pkg::KIND_LOAD, 24'h000007, 1'b1, 2,  0, -1, '0},
         '{acc_pkg::KIND_LOAD, 24'h000008, 1'b1, 1,  0, -1, '0},
         '{acc_pkg::KIND_END,  24'h000000, 1'b0, 1,  0, -1, '0},
         // run out of order, then a lone hit after a gap
         '{acc_pkg::KIND_LOAD, 24'h000003, 1'b1, 3, -1, -1, '0},
         '{acc_pkg::KIND_LOAD, 24'h00000A, 1'b1, 1,  0, -1, '0},
         '{acc_pkg::KIND_END,  24'h000000, 1'b0, 1,  0, -1, '0},
         // full store in descending order (slowest sort): the 65th hit is dropped
         '{acc_pkg::KIND_LOAD, 24'h00013F, 1'b1, 65, -1, -1, '0},
         '{acc_pkg::KIND_LOAD, 24'h555555, 1'b0, 1,  0, -1, '0},
         '{acc_pkg::KIND_END,  24'hAAAAAA, 1'b1, 1,  0,  1, {24'h000100, 7'd64, 1'b1, 1'b1}},
         '{acc_pkg::KIND_LOAD, 24'hAAAAAA, 1'b1, 1,  0, -1, '0},
         '{acc_pkg::KIND_END,  24'h555555, 1'b0, 1,  0,  1, {24'hAAAAAA, 7'd1, 1'b1, 1'b0}},
         '{acc_pkg::KIND_END,  24'h000000, 1'b0, 1,  0,  0, '0}
      };

      repeat (9) @(negedge clock);
      reset = 1'b0;

      items = 0;
      foreach (plan[r]) begin
         for (int k = 0; k < plan[r].reps; k++) begin
            send_req(plan[r].kind, plan[r].id + acc_pkg::ID_PORT_W'(k * plan[r].step),
                     plan[r].hv, plan[r].n_exp, plan[r].want);
            items++;
         end
      end

      // random events: mostly hits clustered around a base, some noise
      ev = 0;
      while (items < 150) begin
         quiet = (ev >= 5 && ev < 8);
         if (ev == 2)
            n_hits = 12;
         else
            n_hits = $urandom_range(0, 12);
         base = acc_pkg::ID_PORT_W'($urandom);
         spread = $urandom_range(1, 3) * n_hits + 1;
         for (int h = 0; h < n_hits; h++) begin
            style = $urandom_range(99);
            hv = 1'b1;
            if (style < 10) begin
               hv = 1'b0;
               id = acc_pkg::ID_PORT_W'($urandom);
            end else if (style < 15) begin
               id = acc_pkg::ID_PORT_W'($urandom);
            end else begin
               id = base + acc_pkg::ID_PORT_W'($urandom_range(0, spread));
            end
            items++;
            send_req(acc_pkg::KIND_LOAD, id, hv, -1, '0);
         end
         // hold results back so the next event backs up against the input
         if (ev == 2)
            squeeze = 1'b1;
         send_req(acc_pkg::KIND_END, acc_pkg::ID_PORT_W'($urandom), 1'($urandom_range(1)),
                  -1, '0);
         items++;
         ev++;
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (expected_clusters.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
